// ----- rtl/core/ship_rrip_stream_replacement_core_macros.svh -----
// ----------------------------------------------------------------------------
// ship rrip stream replacement core - assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SHIP_RRIP_STREAM_REPLACEMENT_CORE_MACROS_SVH
`define SHIP_RRIP_STREAM_REPLACEMENT_CORE_MACROS_SVH

// same-cycle implication under reset
`define SRRIP_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define SRRIP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/srrip_pkg.sv -----
// ----------------------------------------------------------------------------
// srrip_pkg
// shared constants, types and codes of the replacement core
// ----------------------------------------------------------------------------
package srrip_pkg;

    localparam int NUM_SETS      = 2048;
    localparam int NUM_WAYS      = 16;
    localparam int SIG_BITS      = 6;
    localparam int HISTORY_DEPTH = 8;

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int WAY_W     = 4;
    localparam int WAY_IDX_W = $clog2(NUM_WAYS);
    localparam int PTR_W     = $clog2(HISTORY_DEPTH);
    localparam int ADDR_W    = 64;
    localparam int CNT_W     = $clog2(HISTORY_DEPTH) + 1;
    localparam int SIG_COUNT = 1 << SIG_BITS;
    localparam int CLR_LEN   = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
    localparam int CLR_W     = $clog2(CLR_LEN) + 1;

    localparam logic [1:0] RRPV_FAR   = 2'd3;
    localparam logic [1:0] RRPV_NEAR  = 2'd1;
    localparam logic [1:0] RRPV_HIT   = 2'd0;
    localparam logic [1:0] CTR_MAX    = 2'd3;
    localparam logic [1:0] CTR_MIN    = 2'd0;
    localparam logic [1:0] CTR_RESET  = 2'd1;
    localparam logic [ADDR_W-1:0] STRIDE_POS = 64'd64;
    localparam logic [ADDR_W-1:0] STRIDE_NEG = 64'hFFFF_FFFF_FFFF_FFC0;

    localparam logic [2:0] THR_RESET   = 3'd6;
    localparam logic [1:0] REUSE_RESET = 2'd2;

    // configuration register indexes
    localparam logic CFG_STREAM_THRESHOLD = 1'b0;
    localparam logic CFG_REUSE_LEVEL      = 1'b1;

    // command codes
    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [SET_W-1:0]    set;
        logic [WAY_W-1:0]    way;
        logic [ADDR_W-1:0]   addr;
        logic [SIG_BITS-1:0] sig;
        logic                hit;
        logic                victim;
    } item_t;

    typedef struct packed {
        logic [HISTORY_DEPTH-1:0][ADDR_W-1:0] hist;
        logic [PTR_W-1:0]                     ptr;
        logic [NUM_WAYS-1:0][SIG_BITS-1:0]    sig;
        logic [NUM_WAYS-1:0][1:0]             rrpv;
    } row_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

endpackage

// ----- rtl/core/srrip_front.sv -----
// ----------------------------------------------------------------------------
// srrip_front
// accepts request items, decodes fields and signature, feeds the queue
// ----------------------------------------------------------------------------
module srrip_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // set[10:0] way[14:11] phys_address[78:15] program_counter[142:79]
    // was_hit[143] victim_present[144] zero pad[151:145]
    input  logic [151:0]         s_tdata,
    // command[0]
    input  logic [0:0]           s_tuser,
    input  srrip_pkg::fifo_stat_t q_stat,
    output logic                 q_push,
    output srrip_pkg::item_t     q_item
);
    import srrip_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    item_t item_dec;

    // field decode
    always_comb
    begin
        item_dec.cmd    = s_tuser[0];
        item_dec.set    = s_tdata[SET_W-1:0];
        item_dec.way    = s_tdata[14:11];
        item_dec.addr   = s_tdata[78:15];
        item_dec.sig    = s_tdata[79+SIG_BITS+1:79+2];
        item_dec.hit    = s_tdata[143];
        item_dec.victim = s_tdata[144];
    end

    assign q_push   = valid_reg && !q_stat.full;
    assign s_tready = !valid_reg || q_push;
    assign q_item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (q_push)
        begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_dec;
        end
    end

endmodule

// ----- rtl/core/srrip_queue.sv -----
// ----------------------------------------------------------------------------
// srrip_queue
// two-entry queue between the front and the back sequencer
// ----------------------------------------------------------------------------
module srrip_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  srrip_pkg::item_t      push_item,
    input  logic                  pop,
    output srrip_pkg::item_t      pop_item,
    output srrip_pkg::fifo_stat_t stat
);
    import srrip_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.empty = (count_reg == 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign pop_item   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !stat.full)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop && !stat.empty)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push && !stat.full, pop && !stat.empty})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !stat.full)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/srrip_back.sv -----
// ----------------------------------------------------------------------------
// srrip_back
// sequencer: set-row read-modify-write, outcome counters, result register
// ----------------------------------------------------------------------------
module srrip_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [0:0]            cfg_index,
    input  logic [2:0]            cfg_data,
    input  srrip_pkg::fifo_stat_t q_stat,
    input  srrip_pkg::item_t      q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // victim_way[3:0] streaming_seen[4] inserted_rrpv[6:5] zero pad[7]
    output logic [7:0]            m_tdata
);
    import srrip_pkg::*;

    // memories
    row_t       set_mem [NUM_SETS];
    logic [1:0] ctr_mem [SIG_COUNT];

    logic                row_we, row_re;
    logic [SET_W-1:0]    row_waddr, row_raddr;
    row_t                row_wdata, row_q;
    logic                ctr_we, ctr_re;
    logic [SIG_BITS-1:0] ctr_waddr, ctr_raddr;
    logic [1:0]          ctr_wdata, ctr_q;

    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    item_t               item_reg, item_next;
    row_t                upd_row_reg, upd_row_next;
    logic                stream_reg, stream_next;
    logic [1:0]          cnt_sig_reg, cnt_sig_next;
    logic [SIG_BITS-1:0] old_sig_reg, old_sig_next;
    logic [2:0]          thr_reg, thr_next;
    logic [1:0]          reuse_reg, reuse_next;

    logic                out_valid_reg, out_valid_next;
    logic [WAY_W-1:0]    out_way_reg, out_way_next;
    logic                out_stream_reg, out_stream_next;
    logic [1:0]          out_ins_reg, out_ins_next;
    logic                out_load;
    logic                out_free;

    // scan and update helpers
    logic                 far_found, two_found;
    logic [WAY_IDX_W-1:0] far_way, two_way, find_way;
    row_t                 aged_row, hist_row, exec_row, clear_row;
    logic [CNT_W-1:0]     stride_cnt;
    logic [ADDR_W-1:0]    diff;
    logic                 streaming;
    logic                 way_ok;
    logic [WAY_IDX_W-1:0] way_sel;
    logic [1:0]           ins;

    assign out_free = !out_valid_reg || m_tready;
    assign way_ok   = (int'(item_reg.way) < NUM_WAYS);
    assign way_sel  = WAY_IDX_W'(item_reg.way);

    // reset row pattern
    always_comb
    begin
        clear_row = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            clear_row.rrpv[w] = RRPV_FAR;
        end
    end

    // find: lowest far way, aging, lowest way that ages to far
    always_comb
    begin
        far_found = 1'b0;
        two_found = 1'b0;
        far_way   = '0;
        two_way   = '0;
        aged_row  = row_q;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (row_q.rrpv[w] == RRPV_FAR)
            begin
                far_found = 1'b1;
                far_way   = WAY_IDX_W'(w);
            end
            if (row_q.rrpv[w] == RRPV_FAR - 2'd1)
            begin
                two_found = 1'b1;
                two_way   = WAY_IDX_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (row_q.rrpv[w] != RRPV_FAR)
            begin
                aged_row.rrpv[w] = row_q.rrpv[w] + 2'd1;
            end
        end
        if (far_found)
        begin
            find_way = far_way;
        end
        else if (two_found)
        begin
            find_way = two_way;
        end
        else
        begin
            find_way = '0;
        end
    end

    // update: record address, count block strides
    always_comb
    begin
        hist_row                = row_q;
        hist_row.hist[row_q.ptr] = item_reg.addr;
        hist_row.ptr            = row_q.ptr + PTR_W'(1);
        stride_cnt              = '0;
        diff                    = '0;
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            diff = hist_row.hist[i] - hist_row.hist[i-1];
            if (diff == STRIDE_POS || diff == STRIDE_NEG)
            begin
                stride_cnt = stride_cnt + CNT_W'(1);
            end
        end
        streaming = (int'(stride_cnt) >= int'(thr_reg));
    end

    // update: insertion value and way row
    always_comb
    begin
        if (item_reg.hit)
        begin
            ins = RRPV_HIT;
        end
        else if (stream_reg)
        begin
            ins = RRPV_FAR;
        end
        else if (cnt_sig_reg >= reuse_reg)
        begin
            ins = RRPV_NEAR;
        end
        else
        begin
            ins = RRPV_FAR;
        end
        exec_row = upd_row_reg;
        if (way_ok)
        begin
            exec_row.rrpv[way_sel] = ins;
            if (!item_reg.hit)
            begin
                exec_row.sig[way_sel] = item_reg.sig;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        item_next    = item_reg;
        upd_row_next = upd_row_reg;
        stream_next  = stream_reg;
        cnt_sig_next = cnt_sig_reg;
        old_sig_next = old_sig_reg;
        q_pop        = 1'b0;
        row_we       = 1'b0;
        row_re       = 1'b0;
        row_waddr    = item_reg.set;
        row_raddr    = q_item.set;
        row_wdata    = exec_row;
        ctr_we       = 1'b0;
        ctr_re       = 1'b0;
        ctr_waddr    = item_reg.sig;
        ctr_raddr    = q_item.sig;
        ctr_wdata    = cnt_sig_reg;
        out_load     = 1'b0;
        out_way_next    = out_way_reg;
        out_stream_next = out_stream_reg;
        out_ins_next    = out_ins_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                row_we    = (int'(clr_reg) < NUM_SETS);
                row_waddr = SET_W'(clr_reg);
                row_wdata = clear_row;
                ctr_we    = (int'(clr_reg) < SIG_COUNT);
                ctr_waddr = SIG_BITS'(clr_reg);
                ctr_wdata = CTR_RESET;
                if (int'(clr_reg) == CLR_LEN - 1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    row_re     = 1'b1;
                    ctr_re     = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (item_reg.cmd == CMD_FIND)
                begin
                    if (out_free)
                    begin
                        // the set ages only when no way is far
                        row_we          = !far_found;
                        row_wdata       = aged_row;
                        out_load        = 1'b1;
                        out_way_next    = WAY_W'(find_way);
                        out_stream_next = 1'b0;
                        out_ins_next    = 2'd0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    upd_row_next = hist_row;
                    stream_next  = streaming;
                    cnt_sig_next = ctr_q;
                    old_sig_next = row_q.sig[way_sel];
                    ctr_re       = 1'b1;
                    ctr_raddr    = row_q.sig[way_sel];
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    row_we = 1'b1;
                    if (item_reg.hit)
                    begin
                        ctr_we    = 1'b1;
                        ctr_waddr = item_reg.sig;
                        ctr_wdata = (cnt_sig_reg == CTR_MAX) ? CTR_MAX
                                                             : cnt_sig_reg + 2'd1;
                    end
                    else if (way_ok && item_reg.victim)
                    begin
                        ctr_we    = 1'b1;
                        ctr_waddr = old_sig_reg;
                        ctr_wdata = (ctr_q == CTR_MIN) ? CTR_MIN : ctr_q - 2'd1;
                    end
                    out_load        = 1'b1;
                    out_way_next    = '0;
                    out_stream_next = stream_reg;
                    out_ins_next    = ins;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        thr_next   = thr_reg;
        reuse_next = reuse_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index[0])
                CFG_STREAM_THRESHOLD: thr_next   = cfg_data;
                CFG_REUSE_LEVEL:      reuse_next = cfg_data[1:0];
                default:              thr_next   = thr_reg;
            endcase
        end
    end

    // result valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ins_reg, out_stream_reg, out_way_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THR_RESET;
            reuse_reg     <= REUSE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            thr_reg       <= thr_next;
            reuse_reg     <= reuse_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        upd_row_reg    <= upd_row_next;
        stream_reg     <= stream_next;
        cnt_sig_reg    <= cnt_sig_next;
        old_sig_reg    <= old_sig_next;
        out_way_reg    <= out_way_next;
        out_stream_reg <= out_stream_next;
        out_ins_reg    <= out_ins_next;
    end

    // set-row memory
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            set_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_q <= set_mem[row_raddr];
        end
    end

    // outcome counter memory
    always_ff @(posedge clk)
    begin
        if (ctr_we)
        begin
            ctr_mem[ctr_waddr] <= ctr_wdata;
        end
        if (ctr_re)
        begin
            ctr_q <= ctr_mem[ctr_raddr];
        end
    end

endmodule

// ----- rtl/core/ship_rrip_stream_replacement_core.sv -----
// flow: requests pass the front register and the queue to the back sequencer,
// which pops one only in idle; a find runs through the read state and an update
// through read and exec, a read-modify-write of the row and counter memories
// reset: after rst_n rises a clearing pass writes every set row and
// counter; requests queue up (two in the queue, one in the front) until it ends
// ----------------------------------------------------------------------------
// ship_rrip_stream_replacement_core
// rrip replacement with signature outcome counters and per-set stream detect
// ----------------------------------------------------------------------------
module ship_rrip_stream_replacement_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [2:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // set_index[10:0] way_index[14:11] phys_address[78:15]
    // program_counter[142:79] was_hit[143] victim_present[144] zero pad[151:145]
    input  logic [151:0] s_tdata,
    // command[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // victim_way[3:0] streaming_seen[4] inserted_rrpv[6:5] zero pad[7]
    output logic [7:0]   m_tdata
);
    import srrip_pkg::*;

    fifo_stat_t q_stat;
    logic       q_push, q_pop;
    item_t      push_item, pop_item;

    srrip_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    srrip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    srrip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- rtl/core/srrip_checker.sv -----
// ----------------------------------------------------------------------------
// srrip_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "ship_rrip_stream_replacement_core_macros.svh"

module srrip_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result holds
    `SRRIP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a find result carries only a way
    `SRRIP_ASSERT_NOW(a_find_clean, clk, rst_n, m_tvalid && (m_tdata[3:0] != 4'd0), m_tdata[6:4] == 3'd0)

    // inserted value is never two
    `SRRIP_ASSERT_NOW(a_ins_code, clk, rst_n, m_tvalid, m_tdata[6:5] != 2'd2)

    // a streaming miss inserts far
    `SRRIP_ASSERT_NOW(a_stream_far, clk, rst_n, m_tvalid && m_tdata[4] && (m_tdata[6:5] != 2'd0), m_tdata[6:5] == 2'd3)

endmodule

bind ship_rrip_stream_replacement_core srrip_checker u_srrip_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replacement core testbench
// drives find and update requests over the stream port, predicts the victim
// way, stream judgment and inserted value, and compares every result in order
// ----------------------------------------------------------------------------
module testbench;
    import srrip_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 20;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [0:0]   cfg_index;
    logic [2:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    ship_rrip_stream_replacement_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state
    logic [1:0]        rrpv_mem [NUM_SETS*NUM_WAYS];
    logic [5:0]        sig_mem  [NUM_SETS*NUM_WAYS];
    logic [1:0]        ctr_mem  [SIG_COUNT];
    logic [63:0]       hist_mem [NUM_SETS*HISTORY_DEPTH];
    logic [2:0]        ptr_mem  [NUM_SETS];
    logic [2:0]        thr_reg;
    logic [1:0]        reuse_reg;

    logic [6:0]        expected_q [$];
    int                mismatch_count;
    int                idle_cycles;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                hold_recv;
    int                hold_cycles;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [6:0] predict(input logic cmd, input logic [10:0] set,
                                           input logic [3:0] way, input logic [63:0] addr,
                                           input logic [63:0] pc, input logic hit,
                                           input logic victim);
        int          base;
        int          hb;
        int          cnt;
        int          w;
        bit          found;
        logic [5:0]  s;
        logic [63:0] d;
        logic        strm;
        logic [1:0]  ins;
        base = int'(set) * NUM_WAYS;
        s = pc[7:2];
        if (cmd == CMD_FIND)
        begin
            found = 0;
            w = 0;
            for (int k = 0; k < NUM_WAYS; k++)
                if (!found && rrpv_mem[base+k] == RRPV_FAR)
                begin
                    found = 1;
                    w = k;
                end
            if (!found)
            begin
                for (int k = 0; k < NUM_WAYS; k++)
                    if (rrpv_mem[base+k] < RRPV_FAR)
                        rrpv_mem[base+k] = rrpv_mem[base+k] + 2'd1;
                for (int k = 0; k < NUM_WAYS; k++)
                    if (!found && rrpv_mem[base+k] == RRPV_FAR)
                    begin
                        found = 1;
                        w = k;
                    end
            end
            return {3'b000, w[3:0]};
        end
        // history and stream judgment
        hb = int'(set) * HISTORY_DEPTH;
        hist_mem[hb + ptr_mem[set]] = addr;
        ptr_mem[set] = ptr_mem[set] + 3'd1;
        cnt = 0;
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            d = hist_mem[hb+i] - hist_mem[hb+i-1];
            if (d == STRIDE_POS || d == STRIDE_NEG)
                cnt++;
        end
        strm = (cnt >= int'(thr_reg));
        if (hit)
        begin
            rrpv_mem[base+way] = RRPV_HIT;
            if (ctr_mem[s] < CTR_MAX)
                ctr_mem[s] = ctr_mem[s] + 2'd1;
            return {2'b00, strm, 4'd0};
        end
        if (strm)
            ins = RRPV_FAR;
        else if (ctr_mem[s] >= reuse_reg)
            ins = RRPV_NEAR;
        else
            ins = RRPV_FAR;
        rrpv_mem[base+way] = ins;
        if (victim && ctr_mem[sig_mem[base+way]] > 0)
            ctr_mem[sig_mem[base+way]] = ctr_mem[sig_mem[base+way]] - 2'd1;
        sig_mem[base+way] = s;
        return {ins, strm, 4'd0};
    endfunction

    // send one request, predicting at acceptance
    task automatic send_request(input logic cmd, input logic [10:0] set,
                                input logic [3:0] way, input logic [63:0] addr,
                                input logic [63:0] pc, input logic hit,
                                input logic victim);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, victim, hit, pc, addr, way, set};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(predict(cmd, set, way, addr, pc, hit, victim));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [2:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_STREAM_THRESHOLD)
            thr_reg = val;
        else
            reuse_reg = val[1:0];
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // stride run of updates to one set, random hit and miss pattern, finds mixed in
    task automatic stream_run(input logic [10:0] set, input int len);
        logic [63:0] a;
        logic [63:0] pc;
        a  = rand64();
        pc = rand64();
        for (int i = 0; i < len; i++)
        begin
            send_request(CMD_UPDATE, set, $urandom_range(15), a, pc,
                         $urandom_range(1), $urandom_range(1));
            a = ($urandom_range(1)) ? a + 64'd64 : a - 64'd64;
            if ($urandom_range(3) == 0)
                send_request(CMD_FIND, set, 4'd0, 64'd0, 64'd0, 1'b0, 1'b0);
        end
    endtask

    // random mixed traffic, mostly in a small pool of sets
    task automatic random_traffic(input int count);
        logic [10:0] set;
        for (int i = 0; i < count; i++)
        begin
            set = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(7));
            if ($urandom_range(2) == 0)
                send_request(CMD_FIND, set, 4'($urandom), rand64(), rand64(),
                             $urandom_range(1), $urandom_range(1));
            else if ($urandom_range(1))
                stream_run(set, $urandom_range(3, 9));
            else
                send_request(CMD_UPDATE, set, 4'($urandom), rand64(),
                             {$urandom, 24'd0, 2'($urandom_range(3)) == 0 ? 8'hFC : 8'($urandom)},
                             $urandom_range(1), $urandom_range(1));
        end
    endtask

    task automatic test_directed();
        // empty set find, aging with all ways near, extremes of fields
        send_request(CMD_FIND, 11'd0, 4'd0, 64'd0, 64'd0, 1'b0, 1'b0);
        for (int w = 0; w < NUM_WAYS; w++)
            send_request(CMD_UPDATE, 11'd2047, w[3:0], 64'hFFFF_FFFF_FFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_request(CMD_FIND, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_request(CMD_FIND, 11'd2047, 4'd0, 64'd0, 64'd0, 1'b0, 1'b0);
        send_request(CMD_FIND, 11'd2047, 4'd0, 64'd0, 64'd0, 1'b0, 1'b0);
        send_request(CMD_UPDATE, 11'd5, 4'd3, 64'd64, 64'hFC, 1'b0, 1'b1);
        send_request(CMD_UPDATE, 11'd5, 4'd3, 64'd0, 64'h0, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_threshold_extremes();
        // zero threshold makes every update streaming
        write_register(CFG_STREAM_THRESHOLD, 3'd0);
        write_register(CFG_REUSE_LEVEL, 3'd0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_traffic(30);
        wait_drained();
        write_register(CFG_STREAM_THRESHOLD, 3'd7);
        write_register(CFG_REUSE_LEVEL, 3'd3);
        stream_run(11'd9, 10);
        random_traffic(20);
        wait_drained();
    endtask

    task automatic test_sender_idle();
        write_register(CFG_STREAM_THRESHOLD, 3'd3);
        write_register(CFG_REUSE_LEVEL, 3'd1);
        send_idle_pct = 78;
        recv_stall_pct = 0;
        random_traffic(30);
        wait_drained();
    endtask

    task automatic test_receiver_stall();
        write_register(CFG_STREAM_THRESHOLD, 3'd6);
        write_register(CFG_REUSE_LEVEL, 3'd2);
        send_idle_pct = 0;
        recv_stall_pct = 78;
        random_traffic(30);
        wait_drained();
    endtask

    task automatic test_both_idle();
        write_register(CFG_STREAM_THRESHOLD, 3'd1);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        random_traffic(35);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // long receiver hold while the sender keeps offering requests
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        hold_recv = 1'b1;
        random_traffic(25);
        wait_drained();
    endtask

    // receiver ready and long hold
    always @(posedge clk)
    begin
        if (hold_recv)
        begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
            if (hold_cycles <= 0)
                hold_recv = 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        logic [6:0] exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (m_tdata[3:0] !== exp_res[3:0] || m_tdata[4] !== exp_res[4]
                    || m_tdata[6:5] !== exp_res[6:5])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: way exp %0d got %0d, stream exp %0d got %0d, rrpv exp %0d got %0d",
                                 exp_res[3:0], m_tdata[3:0], exp_res[4], m_tdata[4],
                                 exp_res[6:5], m_tdata[6:5]);
                end
            end
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        foreach (rrpv_mem[i]) rrpv_mem[i] = RRPV_FAR;
        foreach (sig_mem[i]) sig_mem[i] = '0;
        foreach (ctr_mem[i]) ctr_mem[i] = CTR_RESET;
        foreach (hist_mem[i]) hist_mem[i] = '0;
        foreach (ptr_mem[i]) ptr_mem[i] = '0;
        thr_reg = THR_RESET;
        reuse_reg = REUSE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_threshold_extremes();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/srrip_pkg.sv
rtl/core/srrip_front.sv
rtl/core/srrip_queue.sv
rtl/core/srrip_back.sv
rtl/core/ship_rrip_stream_replacement_core.sv
rtl/core/srrip_checker.sv
tb/testbench.sv
